// ===== rtl/mbba_pkg.sv =====
// shared types, widths and codes of the multi-block bump allocator
package mbba_pkg;

  // defaults of the top-level parameters
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int ADDR_BITS_DEF  = 40;

  // field widths of the word formats
  localparam int TYPE_W     = 5;
  localparam int SIZE_W     = 40;
  localparam int ALIGN_W    = 31;
  localparam int IDX_OUT_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 40;

  // register reset values
  localparam logic [SIZE_W-1:0]  PREF_RESET = 40'd67108864;
  localparam logic [ALIGN_W-1:0] GRAN_RESET = 31'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PREF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAN = 1'b1;

  // operation codes
  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_OPENED  = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_OPEN,
    S_FULL,
    S_CLEAR
  } state_t;

  // input word
  typedef struct packed {
    logic               operation;
    logic [TYPE_W-1:0]  heap_type;
    logic [SIZE_W-1:0]  request_size;
    logic [ALIGN_W-1:0] request_alignment;
    logic               is_linear;
  } in_word_t;

  // result word
  typedef struct packed {
    status_t              status;
    logic [IDX_OUT_W-1:0] block_index;
    logic [SIZE_W-1:0]    placed_offset;
    logic [SIZE_W-1:0]    new_capacity;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic place;
    logic open;
    logic full;
    logic clear;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic busy;
    logic scan_done;
    logic table_full;
    logic out_stall;
  } ctl_stat_t;

endpackage

// ===== rtl/mbba_ctrl.sv =====
// controller state machine of the multi-block bump allocator
module mbba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  input  mbba_pkg::ctl_stat_t stat,
  output logic                in_ready,
  output mbba_pkg::ctl_cmd_t  cmd
);
  import mbba_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_op == OP_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          state_nxt = S_PLACE;
        end else if (stat.scan_done && !stat.busy) begin
          state_nxt = stat.table_full ? S_FULL : S_OPEN;
        end
      end
      S_PLACE, S_OPEN, S_FULL, S_CLEAR: begin
        if (!stat.out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN:  cmd.scan  = 1'b1;
      S_PLACE: cmd.place = !stat.out_stall;
      S_OPEN:  cmd.open  = !stat.out_stall;
      S_FULL:  cmd.full  = !stat.out_stall;
      S_CLEAR: cmd.clear = !stat.out_stall;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/mbba_datapath.sv =====
// block table, scan pipeline, config registers and result register
module mbba_datapath #(
  parameter int MAX_BLOCKS = mbba_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = mbba_pkg::ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mbba_pkg::in_word_t                  in_word,
  input  mbba_pkg::ctl_cmd_t                  cmd,
  output mbba_pkg::ctl_stat_t                 stat,
  input  logic                                cfg_valid,
  input  logic [mbba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbba_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mbba_pkg::out_word_t                 out_word
);
  import mbba_pkg::*;

  localparam int STORE_W = (ADDR_BITS < SIZE_W) ? ADDR_BITS : SIZE_W;
  localparam int BASE_W  = (STORE_W > ALIGN_W) ? STORE_W : ALIGN_W;
  localparam int CW      = BASE_W + 3;
  localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int OPEN_W  = $clog2(MAX_BLOCKS + 1);

  // round v up with mask a-1, no rounding for a of zero or one
  function automatic logic [CW-1:0] round_up(input logic [CW-1:0] v,
                                             input logic [CW-1:0] a);
    logic [CW-1:0] am1;
    am1 = a - CW'(1);
    if (a <= CW'(1)) begin
      round_up = v;
    end else begin
      round_up = (v + am1) & ~am1;
    end
  endfunction

  // block table memory
  logic [TYPE_W-1:0]  mem_type [MAX_BLOCKS];
  logic [STORE_W-1:0] mem_cap  [MAX_BLOCKS];
  logic [STORE_W-1:0] mem_used [MAX_BLOCKS];
  logic               mem_lin  [MAX_BLOCKS];

  // config and control registers
  logic [STORE_W-1:0] pref_r;
  logic [ALIGN_W-1:0] gran_r;
  logic [OPEN_W-1:0]  open_r;
  logic [OPEN_W-1:0]  rd_cnt_r;
  logic               s1_v_r, s2_v_r, s3_v_r;
  logic               out_valid_r;

  // request registers
  logic [TYPE_W-1:0]  req_type_r;
  logic [STORE_W-1:0] req_size_r;
  logic [ALIGN_W-1:0] req_align_r;
  logic               req_lin_r;

  // scan pipeline payload
  logic [IDX_W-1:0]   s1_idx_r, s2_idx_r, s3_idx_r;
  logic [TYPE_W-1:0]  s1_type_r;
  logic [STORE_W-1:0] s1_cap_r, s2_cap_r, s3_cap_r;
  logic [STORE_W-1:0] s1_used_r;
  logic               s1_lin_r;
  logic               s2_match_r, s3_match_r;
  logic               s2_mis_r;
  logic [CW-1:0]      s2_off_r, s3_off_r;

  // captured hit
  logic [IDX_W-1:0]   hit_idx_r;
  logic [STORE_W-1:0] hit_off_r, hit_end_r, hit_cap_r;

  out_word_t          out_word_r;
  out_word_t          res;

  logic [IDX_W-1:0]   rd_addr;
  logic               issue, hit, flush, commit, wr_en;
  logic [CW:0]        fit_sum, cap_ext;
  logic [IDX_W-1:0]   wr_addr;
  logic [STORE_W-1:0] wr_cap, wr_used, new_cap;
  logic [IDX_W-1:0]   res_idx;
  logic [IDX_W+IDX_OUT_W-1:0]  idx_wide;
  logic [STORE_W+SIZE_W-1:0]   off_wide, cap_wide;
  logic [STORE_W-1:0] res_off, res_cap;

  // fit check on the last pipeline stage
  always_comb begin
    fit_sum = {1'b0, s3_off_r} + {{(CW + 1 - STORE_W){1'b0}}, req_size_r};
    cap_ext = {{(CW + 1 - STORE_W){1'b0}}, s3_cap_r};
    hit     = s3_v_r && s3_match_r && (fit_sum <= cap_ext);
  end

  assign rd_addr = rd_cnt_r[IDX_W-1:0];
  assign flush   = cmd.scan && hit;
  assign issue   = cmd.scan && !hit && (rd_cnt_r < open_r);
  assign commit  = cmd.place || cmd.open || cmd.full || cmd.clear;
  assign new_cap = (pref_r > req_size_r) ? pref_r : req_size_r;

  // status to the controller
  always_comb begin
    stat.hit        = hit;
    stat.busy       = s1_v_r || s2_v_r || s3_v_r;
    stat.scan_done  = (rd_cnt_r >= open_r);
    stat.table_full = (open_r == OPEN_W'(MAX_BLOCKS));
    stat.out_stall  = out_valid_r && !out_ready;
  end

  // control state: config, counters, pipeline valids, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pref_r      <= PREF_RESET[STORE_W-1:0];
      gran_r      <= GRAN_RESET;
      open_r      <= '0;
      rd_cnt_r    <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_PREF: pref_r <= cfg_data[STORE_W-1:0];
          CFG_GRAN: gran_r <= cfg_data[ALIGN_W-1:0];
          default:  gran_r <= gran_r;
        endcase
      end
      priority if (cmd.load) begin
        rd_cnt_r <= '0;
      end else if (issue) begin
        rd_cnt_r <= rd_cnt_r + OPEN_W'(1);
      end
      priority if (cmd.clear) begin
        open_r <= '0;
      end else if (cmd.open) begin
        open_r <= open_r + OPEN_W'(1);
      end
      if (flush) begin
        s1_v_r <= 1'b0;
        s2_v_r <= 1'b0;
        s3_v_r <= 1'b0;
      end else begin
        s1_v_r <= issue;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
      end
      priority if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r  <= in_word.heap_type;
      req_size_r  <= in_word.request_size[STORE_W-1:0];
      req_align_r <= in_word.request_alignment;
      req_lin_r   <= in_word.is_linear;
    end
  end

  // table read, registered data
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_idx_r  <= rd_addr;
      s1_type_r <= mem_type[rd_addr];
      s1_cap_r  <= mem_cap[rd_addr];
      s1_used_r <= mem_used[rd_addr];
      s1_lin_r  <= mem_lin[rd_addr];
    end
  end

  // alignment and kind padding stages
  always_ff @(posedge clk) begin
    s2_idx_r   <= s1_idx_r;
    s2_cap_r   <= s1_cap_r;
    s2_match_r <= (s1_type_r == req_type_r);
    s2_mis_r   <= (s1_lin_r != req_lin_r);
    s2_off_r   <= round_up({{(CW - STORE_W){1'b0}}, s1_used_r},
                           {{(CW - ALIGN_W){1'b0}}, req_align_r});
    s3_idx_r   <= s2_idx_r;
    s3_cap_r   <= s2_cap_r;
    s3_match_r <= s2_match_r;
    s3_off_r   <= s2_mis_r ? round_up(s2_off_r, {{(CW - ALIGN_W){1'b0}}, gran_r})
                           : s2_off_r;
  end

  // first fit capture
  always_ff @(posedge clk) begin
    if (flush) begin
      hit_idx_r <= s3_idx_r;
      hit_off_r <= s3_off_r[STORE_W-1:0];
      hit_end_r <= fit_sum[STORE_W-1:0];
      hit_cap_r <= s3_cap_r;
    end
  end

  // table write on place or open
  assign wr_en   = cmd.place || cmd.open;
  assign wr_addr = cmd.place ? hit_idx_r : open_r[IDX_W-1:0];
  assign wr_cap  = cmd.place ? hit_cap_r : new_cap;
  assign wr_used = cmd.place ? hit_end_r : req_size_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_type[wr_addr] <= req_type_r;
      mem_cap[wr_addr]  <= wr_cap;
      mem_used[wr_addr] <= wr_used;
      mem_lin[wr_addr]  <= req_lin_r;
    end
  end

  // result word
  always_comb begin
    res_idx = '0;
    res_off = '0;
    res_cap = '0;
    res.status = ST_CLEARED;
    priority if (cmd.place) begin
      res.status = ST_PLACED;
      res_idx    = hit_idx_r;
      res_off    = hit_off_r;
    end else if (cmd.open) begin
      res.status = ST_OPENED;
      res_idx    = open_r[IDX_W-1:0];
      res_cap    = new_cap;
    end else if (cmd.full) begin
      res.status = ST_FULL;
    end else begin
      res.status = ST_CLEARED;
    end
    idx_wide          = {{IDX_OUT_W{1'b0}}, res_idx};
    off_wide          = {{SIZE_W{1'b0}}, res_off};
    cap_wide          = {{SIZE_W{1'b0}}, res_cap};
    res.block_index   = idx_wide[IDX_OUT_W-1:0];
    res.placed_offset = off_wide[SIZE_W-1:0];
    res.new_capacity  = cap_wide[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/multi_block_bump_allocator_top.sv =====
// top level of the multi-block first-fit bump allocator
//
// Input channel in_valid/in_ready/in_word takes one word: a place request
// (memory type, size, alignment, linear flag) or a clear of the block table.
// Result channel out_valid/out_ready/out_word returns one word per input:
// placed, new block opened, table full, or cleared.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the preferred
// block size (index 0) or the kind granularity (index 1); always ready.
// A clear is committed from the clear state to the output register. A place
// request reads one block entry per cycle from the table memory through a
// 3-stage read/align/pad pipeline with the fit check on its last stage and
// scans at most MAX_BLOCKS open blocks in index order up to the first fit.
// One word is in flight at a time; the controller returns to idle, ready for
// the next, as the current result is loaded into the output register.
// Reset (rst_n, synchronous) empties the table and restores the config
// defaults; no clearing pass is needed. When the receiver stalls, the result
// holds in the output register and the block waits before its next commit.
module multi_block_bump_allocator_top #(
  parameter int MAX_BLOCKS = mbba_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = mbba_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mbba_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mbba_pkg::out_word_t             out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mbba_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // config writes never stall
  assign cfg_ready = 1'b1;

  // controller
  mbba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_word.operation),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // datapath
  mbba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// ===== tb/multi_block_bump_allocator_top_tb.sv =====
// self-checking testbench of the multi-block bump allocator: directed and random words
`timescale 1ns / 100ps

module multi_block_bump_allocator_top_tb;
  import mbba_pkg::*;

  localparam int TABLE_DEPTH = MAX_BLOCKS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PREF;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  multi_block_bump_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted allocator state and registers
  logic [TYPE_W-1:0] blk_type   [TABLE_DEPTH];
  logic [SIZE_W-1:0] blk_cap    [TABLE_DEPTH];
  logic [SIZE_W-1:0] blk_used   [TABLE_DEPTH];
  logic              blk_linear [TABLE_DEPTH];
  int unsigned       blocks_open = 0;
  logic [SIZE_W-1:0]  pref_bytes  = PREF_RESET;
  logic [ALIGN_W-1:0] granularity = GRAN_RESET;

  // traffic bookkeeping
  in_word_t    pending_words[$];
  out_word_t   placements_due[$];
  int unsigned words_queued = 0;
  int unsigned words_taken  = 0;
  int unsigned cfg_writes   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned settings     = 1;
  int unsigned tally[4]     = '{0, 0, 0, 0};
  bit          in_taken     = 1'b0;
  bit          idle_en      = 1'b0;
  int unsigned in_gap       = 0;
  int unsigned rx_gap       = 0;
  int unsigned hold_req     = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;

  // round v up with the and-not mask, no rounding for 0 or 1
  function automatic bit [63:0] round_to(bit [63:0] v, bit [63:0] a);
    if (a <= 64'd1)
      return v;
    return (v + a - 64'd1) & ~(a - 64'd1);
  endfunction

  // first-fit placement, sums kept 64 bits wide so they never wrap
  function automatic out_word_t predict_allocation(in_word_t w);
    out_word_t   r;
    bit [63:0]   off;
    bit [63:0]   need;
    int unsigned i;
    r = '0;
    if (w.operation == OP_CLEAR) begin
      blocks_open = 0;
      r.status = ST_CLEARED;
      return r;
    end
    for (i = 0; i < blocks_open; i++) begin
      if (blk_type[i] != w.heap_type)
        continue;
      off = round_to(64'(blk_used[i]), 64'(w.request_alignment));
      if (blk_linear[i] != w.is_linear)
        off = round_to(off, 64'(granularity));
      need = off + 64'(w.request_size);
      if (need <= 64'(blk_cap[i])) begin
        blk_used[i]      = need[SIZE_W-1:0];
        blk_linear[i]    = w.is_linear;
        r.status         = ST_PLACED;
        r.block_index    = IDX_OUT_W'(i);
        r.placed_offset  = off[SIZE_W-1:0];
        return r;
      end
    end
    if (blocks_open >= TABLE_DEPTH) begin
      r.status = ST_FULL;
      return r;
    end
    // open a new block at the next index
    i = blocks_open;
    blk_type[i]    = w.heap_type;
    blk_cap[i]     = (pref_bytes > w.request_size) ? pref_bytes : w.request_size;
    blk_used[i]    = w.request_size;
    blk_linear[i]  = w.is_linear;
    blocks_open    = i + 1;
    r.status       = ST_OPENED;
    r.block_index  = IDX_OUT_W'(i);
    r.new_capacity = blk_cap[i];
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  // input word driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // word still on offer
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (pending_words.size() != 0) begin
      if (idle_en && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        in_gap = $urandom_range(0, 9);
      end else begin
        in_word  <= pending_words.pop_front();
        in_valid <= 1'b1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver with random stalls and a long hold on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_gap = $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on accept, check results, watchdog
  always @(posedge clk) begin : watch
    out_word_t want;
    bit        cfg_fire;
    bit        out_fire;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && in_ready;
      cfg_fire = cfg_valid && cfg_ready;
      out_fire = out_valid && out_ready;
      if (in_taken) begin
        placements_due.insert(placements_due.size(), predict_allocation(in_word));
        words_taken++;
      end
      if (cfg_fire) begin
        if (cfg_index == CFG_PREF)
          pref_bytes = cfg_data;
        else
          granularity = cfg_data[ALIGN_W-1:0];
        cfg_writes++;
      end
      if (out_fire) begin
        results_seen++;
        if (placements_due.size() == 0) begin
          flag_mismatch("unexpected word, status", out_word.status, 0);
        end else begin
          want = placements_due.pop_front();
          tally[want.status]++;
          if (out_word.status != want.status)
            flag_mismatch("status", out_word.status, want.status);
          if (out_word.block_index != want.block_index)
            flag_mismatch("block_index", out_word.block_index, want.block_index);
          if (out_word.placed_offset != want.placed_offset)
            flag_mismatch("placed_offset", out_word.placed_offset, want.placed_offset);
          if (out_word.new_capacity != want.new_capacity)
            flag_mismatch("new_capacity", out_word.new_capacity, want.new_capacity);
        end
      end
      if (in_taken || cfg_fire || out_fire)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                 idle_cycles, placements_due.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic in_word_t make_word(logic op, logic [TYPE_W-1:0] mtype,
                                         logic [SIZE_W-1:0] size,
                                         logic [ALIGN_W-1:0] align, logic lin);
    in_word_t w;
    w.operation         = op;
    w.heap_type         = mtype;
    w.request_size      = size;
    w.request_alignment = align;
    w.is_linear         = lin;
    return w;
  endfunction

  // mostly well-formed requests on a few types, some clears and raw noise
  function automatic in_word_t random_word(int unsigned size_cap, bit wide);
    in_word_t    w;
    bit [95:0]   noise;
    bit [63:0]   raw;
    int unsigned pick;
    int unsigned apick;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      noise = {$urandom, $urandom, $urandom};
      w = noise[$bits(in_word_t)-1:0];
      return w;
    end
    w = make_word(OP_PLACE, 5'($urandom_range(0, 3)), '0, '0, 1'($urandom_range(0, 1)));
    if (pick < 8) begin
      w.operation = OP_CLEAR;
      return w;
    end
    if (pick >= 90)
      w.heap_type = 5'($urandom_range(0, 31));
    if (wide) begin
      raw = {$urandom, $urandom};
      raw = raw >> $urandom_range(24, 63);
      w.request_size = (raw[SIZE_W-1:0] == '0) ? SIZE_W'(1) : raw[SIZE_W-1:0];
    end else begin
      w.request_size = SIZE_W'($urandom_range(1, size_cap));
    end
    apick = $urandom_range(0, 7);
    unique case (apick)
      0: w.request_alignment = '0;
      1: w.request_alignment = ALIGN_W'(1);
      6, 7: w.request_alignment = ALIGN_W'($urandom >> $urandom_range(1, 31));
      default: w.request_alignment = ALIGN_W'(1) << $urandom_range(1, wide ? 30 : 12);
    endcase
    return w;
  endfunction

  task automatic queue_word(in_word_t w);
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endtask

  // wait until every word is taken and answered
  task automatic settle();
    do @(negedge clk);
    while (words_taken != words_queued || placements_due.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    int unsigned target;
    target = cfg_writes + 1;
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (cfg_writes != target);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] pref, logic [CFG_DATA_W-1:0] gran,
                           int unsigned count, int unsigned size_cap, bit wide,
                           bit idle, bit hold);
    int unsigned k;
    settle();
    write_reg(CFG_PREF, pref);
    write_reg(CFG_GRAN, gran);
    settings++;
    @(posedge clk);
    idle_en = idle;
    if (hold)
      hold_req++;
    for (k = 0; k < count; k++)
      queue_word(random_word(size_cap, wide));
  endtask

  // stimulus sequence
  initial begin : stimulus
    int k;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_en = 1'b1;

    // directed words under the reset settings
    queue_word(make_word(OP_PLACE, 5'd0, 40'd1, 31'd0, 1'b0));
    queue_word(make_word(OP_PLACE, 5'd0, 40'd100, 31'd1, 1'b1));
    queue_word(make_word(OP_PLACE, 5'd0, 40'd5, 31'd64, 1'b1));
    // alignment that is not a power of two
    queue_word(make_word(OP_PLACE, 5'd0, 40'd7, 31'd3, 1'b0));
    // widest alignment forces a second block of the same type
    queue_word(make_word(OP_PLACE, 5'd0, 40'd1, 31'h4000_0000, 1'b0));
    // largest size, then a zero size that lands at the very end
    queue_word(make_word(OP_PLACE, 5'd31, '1, 31'd0, 1'b1));
    queue_word(make_word(OP_PLACE, 5'd31, '0, 31'd0, 1'b1));
    // oversized requests until the table is full and refuses
    for (k = 0; k < TABLE_DEPTH; k++)
      queue_word(make_word(OP_PLACE, 5'd7, '1, 31'h7FFF_FFFF, 1'(k)));
    queue_word(make_word(OP_CLEAR, '1, '1, '1, 1'b1));

    // random phases over several register settings
    run_phase(40'd4096, 40'd256, 250, 8192, 1'b0, 1'b1, 1'b1);
    run_phase(40'd1, 40'd0, 150, 64, 1'b0, 1'b1, 1'b0);
    run_phase(40'd0, 40'h4000_0000, 60, 64, 1'b0, 1'b1, 1'b0);
    run_phase('1, 40'h4000_0000, 200, 0, 1'b1, 1'b1, 1'b0);
    run_phase(40'd65536, 40'd4096, 300, 100000, 1'b0, 1'b0, 1'b0);
    run_phase(40'd1000, 40'd3, 300, 1500, 1'b0, 1'b1, 1'b0);
    run_phase(40'd67108864, 40'd64, 250, 1 << 27, 1'b0, 1'b0, 1'b0);

    settle();
    repeat (TABLE_DEPTH + 8) @(negedge clk);
    $display("run covered %0d words under %0d register settings, %0d mismatches",
             results_seen, settings, mismatches);
    $display("outcomes: %0d placed, %0d new blocks, %0d refused full, %0d clears",
             tally[ST_PLACED], tally[ST_OPENED], tally[ST_FULL], tally[ST_CLEARED]);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mbba_pkg.sv
rtl/mbba_ctrl.sv
rtl/mbba_datapath.sv
rtl/multi_block_bump_allocator_top.sv
tb/multi_block_bump_allocator_top_tb.sv
